// ===== rtl/lars_pkg.sv =====
// Shared constants, types and helpers of the life automaton row stepper.
package lars_pkg;

   localparam int MAX_COLS  = 64;
   localparam int MAX_ROWS  = 4096;
   localparam int COLS_W    = 7;
   localparam int ROWS_W    = 13;
   localparam int ROW_IDX_W = 12;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'd1;

   localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(MAX_COLS);
   localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_ROWS);

   // result slots of one job, in emit order
   localparam int JOB_MID  = 0;
   localparam int JOB_LAST = 1;
   localparam int JOB_WRAP = 2;
   localparam int JOB_N    = 3;

   typedef logic [MAX_COLS-1:0] row_type;

   typedef struct packed {
      row_type                older;
      row_type                prev;
      row_type                cur;
      row_type                first;
      row_type                second;
      logic [ROW_IDX_W-1:0]   k;
      logic [ROW_IDX_W-1:0]   last_idx;
      logic                   one_row;
   } lars_job_type;

   function automatic row_type col_mask(input logic [COLS_W-1:0] cols);
      col_mask = ~({MAX_COLS{1'b1}} << cols);
   endfunction

endpackage

// ===== rtl/life_automaton_row_stepper.sv =====
// Top level of the life automaton row stepper.
// Takes one row word of the current generation per cycle while req_stall is low, rows
// 0..N-1 in order, and returns next-generation rows: row k-1 when row k arrives (k >= 2),
// and rows N-1 and 0 after the last row (row 0 carries grid_done). The last row of a
// generation holds req_stall while its extra words (up to two: none on a one-row grid,
// one on a two-row grid) leave through the single rule unit and result register;
// a stalled full result register also holds req_stall. A row is first held in the job
// register, and its result word is then computed and captured in the result register.
// Writing either register restarts the generation at row 0; out-of-range values are clamped.
module life_automaton_row_stepper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lars_pkg::row_type              req_row_cells,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lars_pkg::ROW_IDX_W-1:0] rsp_row_index,
   output lars_pkg::row_type              rsp_next_cells,
   output logic                           rsp_grid_done,
   input  logic                           csr_write,
   input  logic [lars_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lars_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import lars_pkg::*;

   logic [ROWS_W-1:0]    rows_ff, rows_in;
   logic [COLS_W-1:0]    cols_ff, cols_in;
   row_type              first_ff, first_in;
   row_type              second_ff, second_in;
   row_type              older_ff, older_in;
   row_type              prev_ff, prev_in;
   logic [ROW_IDX_W-1:0] count_ff, count_in;
   lars_job_type         job_ff, job_in;
   logic [JOB_N-1:0]     mask_ff, mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0] rsp_idx_ff;
   row_type              rsp_cells_ff;
   logic                 rsp_done_ff;

   row_type              cur;
   logic                 is_last;
   logic [JOB_N-1:0]     new_mask;
   logic                 accept, out_load, go, job_free;
   logic [JOB_N-1:0]     rest;
   row_type              sel_up, sel_mid, sel_down, rule_out;
   logic [ROW_IDX_W-1:0] sel_idx;
   logic                 sel_done;
   logic [COLS_W-1:0]    wr_cols;

   assign cur     = req_row_cells & col_mask(cols_ff);
   assign is_last = ({1'b0, count_ff} + ROWS_W'(1)) >= rows_ff;

   always_comb begin
      new_mask = '0;
      new_mask[JOB_MID] = count_ff >= ROW_IDX_W'(2);
      if (is_last) begin
         new_mask[JOB_LAST] = 1'b1;
         new_mask[JOB_WRAP] = rows_ff != ROWS_W'(1);
      end
   end

   // pick the next result slot of the held job
   always_comb begin
      sel_up   = job_ff.cur;
      sel_mid  = job_ff.first;
      sel_down = job_ff.second;
      sel_idx  = '0;
      sel_done = 1'b1;
      rest     = '0;
      priority if (mask_ff[JOB_MID]) begin
         sel_up   = job_ff.older;
         sel_mid  = job_ff.prev;
         sel_down = job_ff.cur;
         sel_idx  = job_ff.k - ROW_IDX_W'(1);
         sel_done = 1'b0;
         rest     = mask_ff & ~(JOB_N'(1) << JOB_MID);
      end else if (mask_ff[JOB_LAST]) begin
         rest = mask_ff & ~(JOB_N'(1) << JOB_LAST);
         if (job_ff.one_row) begin
            sel_up   = job_ff.cur;
            sel_mid  = job_ff.cur;
            sel_down = job_ff.cur;
            sel_idx  = '0;
            sel_done = 1'b1;
         end else begin
            sel_up   = job_ff.prev;
            sel_mid  = job_ff.cur;
            sel_down = job_ff.first;
            sel_idx  = job_ff.last_idx;
            sel_done = 1'b0;
         end
      end else begin
         sel_up   = job_ff.cur;
         sel_mid  = job_ff.first;
         sel_down = job_ff.second;
         sel_idx  = '0;
         sel_done = 1'b1;
         rest     = '0;
      end
   end

   lars_row_rule u_rule (
      .up_cells   (sel_up),
      .mid_cells  (sel_mid),
      .down_cells (sel_down),
      .num_cols   (cols_ff),
      .next_cells (rule_out)
   );

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign go        = (|mask_ff) && out_load;
   assign job_free  = !(|mask_ff) || (go && (rest == '0));
   assign req_stall = !job_free;
   assign accept    = req_valid && job_free;

   assign wr_cols = csr_wdata[COLS_W-1:0];

   always_comb begin
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      first_in  = first_ff;
      second_in = second_ff;
      older_in  = older_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      job_in    = job_ff;
      mask_in   = go ? rest : mask_ff;
      if (accept) begin
         if (count_ff == ROW_IDX_W'(0)) first_in = cur;
         if (count_ff == ROW_IDX_W'(1)) second_in = cur;
         older_in        = prev_ff;
         prev_in         = cur;
         count_in        = is_last ? '0 : count_ff + ROW_IDX_W'(1);
         job_in.older    = older_ff;
         job_in.prev     = prev_ff;
         job_in.cur      = cur;
         job_in.first    = (count_ff == ROW_IDX_W'(0)) ? cur : first_ff;
         job_in.second   = (count_ff == ROW_IDX_W'(1)) ? cur : second_ff;
         job_in.k        = count_ff;
         job_in.last_idx = ROW_IDX_W'(rows_ff - ROWS_W'(1));
         job_in.one_row  = rows_ff == ROWS_W'(1);
         mask_in         = new_mask;
      end
      if (csr_write) begin
         count_in = '0;
         unique case (csr_index)
            CSR_NUM_ROWS: begin
               if (csr_wdata == '0) rows_in = ROWS_W'(1);
               else if (csr_wdata > ROWS_MAX) rows_in = ROWS_MAX;
               else rows_in = csr_wdata;
            end
            CSR_NUM_COLS: begin
               if (wr_cols == '0) cols_in = COLS_W'(1);
               else if (wr_cols > COLS_MAX) cols_in = COLS_MAX;
               else cols_in = wr_cols;
            end
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = out_load ? go : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_W'(64);
         cols_ff      <= COLS_W'(64);
         first_ff     <= '0;
         second_ff    <= '0;
         older_ff     <= '0;
         prev_ff      <= '0;
         count_ff     <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         older_ff     <= older_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (go) begin
         rsp_idx_ff   <= sel_idx;
         rsp_cells_ff <= rule_out;
         rsp_done_ff  <= sel_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_index  = rsp_idx_ff;
   assign rsp_next_cells = rsp_cells_ff;
   assign rsp_grid_done  = rsp_done_ff;

endmodule

// ===== rtl/lars_row_rule.sv =====
// Life rule for one row word with wrapped columns.
module lars_row_rule (
   input  lars_pkg::row_type            up_cells,
   input  lars_pkg::row_type            mid_cells,
   input  lars_pkg::row_type            down_cells,
   input  logic [lars_pkg::COLS_W-1:0]  num_cols,
   output lars_pkg::row_type            next_cells
);
   import lars_pkg::*;

   localparam int SEL_W = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;

   logic [COLS_W-1:0] last_col;
   logic [SEL_W-1:0]  last_sel;
   row_type           last_bit;
   row_type           up_l, up_r, mid_l, mid_r, dn_l, dn_r;
   row_type           rule;
   logic [3:0]        count;

   assign last_col = num_cols - COLS_W'(1);
   assign last_sel = last_col[SEL_W-1:0];
   assign last_bit = row_type'(1) << last_sel;

   // neighbors: bits above the used width are zero, so only the wrap ends need fixing
   assign up_l  = (up_cells << 1)   | row_type'(up_cells[last_sel]);
   assign mid_l = (mid_cells << 1)  | row_type'(mid_cells[last_sel]);
   assign dn_l  = (down_cells << 1) | row_type'(down_cells[last_sel]);
   assign up_r  = (up_cells >> 1)   | (up_cells[0]   ? last_bit : '0);
   assign mid_r = (mid_cells >> 1)  | (mid_cells[0]  ? last_bit : '0);
   assign dn_r  = (down_cells >> 1) | (down_cells[0] ? last_bit : '0);

   always_comb begin
      rule  = '0;
      count = '0;
      for (int j = 0; j < MAX_COLS; j++) begin
         count = 4'(up_l[j]) + 4'(up_cells[j]) + 4'(up_r[j])
               + 4'(mid_l[j]) + 4'(mid_r[j])
               + 4'(dn_l[j]) + 4'(down_cells[j]) + 4'(dn_r[j]);
         rule[j] = (count == 4'd3) || (mid_cells[j] && (count == 4'd2));
      end
   end

   assign next_cells = rule & col_mask(num_cols);

endmodule

// ===== rtl/lars_checker.sv =====
// Port-level checks of the life automaton row stepper, bound to the top level.
module lars_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input lars_pkg::row_type              req_row_cells,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [lars_pkg::ROW_IDX_W-1:0] rsp_row_index,
   input lars_pkg::row_type              rsp_next_cells,
   input logic                           rsp_grid_done,
   input logic                           csr_write,
   input logic [lars_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lars_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import lars_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_next_cells) && $stable(rsp_grid_done))
      else $error("stalled result word changed");

   a_done_row0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_done |-> rsp_row_index == '0)
      else $error("grid_done on a row other than 0");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_word_follows_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result word with no row accepted");

endmodule

bind life_automaton_row_stepper lars_checker u_lars_checker (.*);
